@@ rtl/imc_pkg.sv @@
// ---------------------------------------------------------------------------
// Irrigation mode controller package
// Shared types, field widths, register map and reset values.
// ---------------------------------------------------------------------------
package imc_pkg;

  // Field widths.
  localparam int unsigned SampleW  = 12;
  localparam int unsigned PctW     = 7;
  localparam int unsigned SecW     = 16;
  localparam int unsigned PpsW     = 10;
  localparam int unsigned PressW   = 15;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  // Converter full scale and pressure per percent (3 * 98 Pa).
  localparam logic [12:0]       FullScale   = 13'd4095;
  localparam logic [PressW-1:0] PaPerPct    = 15'd294;
  localparam logic [PpsW-1:0]   PassCountMax = 10'd1023;

  // Register reset values.
  localparam logic [PpsW-1:0] PpsReset   = 10'd10;
  localparam logic [SecW-1:0] DayReset   = 16'd30;
  localparam logic [SecW-1:0] NightReset = 16'd15;
  localparam logic [PctW-1:0] LowReset   = 7'd20;
  localparam logic [PctW-1:0] CritReset  = 7'd10;

  // Register indexes (byte address / 4).
  localparam logic [2:0] RegPps   = 3'd0;
  localparam logic [2:0] RegDay   = 3'd1;
  localparam logic [2:0] RegNight = 3'd2;
  localparam logic [2:0] RegLow   = 3'd3;
  localparam logic [2:0] RegCrit  = 3'd4;

  typedef enum logic [ModeW-1:0] {
    ModeStart    = 3'd0,
    ModeMonitor  = 3'd1,
    ModeWater    = 3'd2,
    ModePaused   = 3'd3,
    ModeLow      = 3'd4,
    ModeCritical = 3'd5
  } mode_e;

endpackage

@@ rtl/irrigation_mode_controller.sv @@
// ---------------------------------------------------------------------------
// Irrigation mode controller
// One control pass per item: updates the six-mode controller, the watering
// countdown and timer, and returns mode, drives, seconds, percent, pressure.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Content
//  s_axis    in         tvalid/tready             sensor bits, tank sample
//  m_axis    out        tvalid/tready             mode, drives, seconds, level
//  apb       in/out     psel/penable/pready       five control registers
//
// Each item is held in the input register (tank percent is captured there)
// and goes through one pass of the mode logic into the result register;
// one item is taken per cycle while results drain.
// The result register decouples the sides; a stalled output holds its item
// and the input register still takes one item, after which it is also full.
// Reset is asynchronous and needs no clearing pass.
// ---------------------------------------------------------------------------
module irrigation_mode_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input items
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [0] soil_dry, [1] presence, [2] daylight, [14:3] tank_sample, [15] zero
  input  logic [imc_pkg::InDataW-1:0]   s_axis_tdata_i,
  // Result items
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [2:0] mode, [3] pump_on, [4] alert_on, [20:5] seconds_left,
  // [27:21] tank_percent, [42:28] pressure_pa, [47:43] zero
  output logic [imc_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [imc_pkg::AddrW-1:0]     paddr,
  input  logic [imc_pkg::DataW-1:0]     pwdata,
  output logic [imc_pkg::DataW-1:0]     prdata,
  output logic                          pready
);
  import imc_pkg::*;

  // Configuration registers.
  logic [PpsW-1:0] pps_q;
  logic [SecW-1:0] day_q, night_q;
  logic [PctW-1:0] low_q, crit_q;
  logic            cfg_wr;

  // Input stage.
  logic            in_valid_q;
  logic            dry_q, pres_q, day_lt_q;
  logic [PctW-1:0] pct_q;
  logic [PctW-1:0] pct_in;
  logic [18:0]     scaled, approx;
  logic [PctW-1:0] quot0;
  logic [18:0]     rem0;
  logic [SampleW-1:0] sample;
  logic            advance;
  logic            in_take;

  // Controller state.
  mode_e           mode_q, mode_n;
  logic [SecW-1:0] cd_q, cd_n, ps_q, ps_n, cs_q, cs_n;
  logic [PctW-1:0] lp_q, lp_n;
  logic            run_q, run_n;
  logic [PpsW-1:0] passes_q, passes_n;
  logic            pump_q, pump_n, alert_q, alert_n;
  logic            fired, mon;

  // Result register.
  logic                  out_valid_q;
  logic [OutDataW-1:0]   out_data_q;
  logic [PressW-1:0]     press_n;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pps_q   <= PpsReset;
      day_q   <= DayReset;
      night_q <= NightReset;
      low_q   <= LowReset;
      crit_q  <= CritReset;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        RegPps:   pps_q   <= pwdata[PpsW-1:0];
        RegDay:   day_q   <= pwdata[SecW-1:0];
        RegNight: night_q <= pwdata[SecW-1:0];
        RegLow:   low_q   <= pwdata[PctW-1:0];
        RegCrit:  crit_q  <= pwdata[PctW-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (paddr[4:2])
      RegPps:   prdata = {{(DataW-PpsW){1'b0}}, pps_q};
      RegDay:   prdata = {{(DataW-SecW){1'b0}}, day_q};
      RegNight: prdata = {{(DataW-SecW){1'b0}}, night_q};
      RegLow:   prdata = {{(DataW-PctW){1'b0}}, low_q};
      RegCrit:  prdata = {{(DataW-PctW){1'b0}}, crit_q};
      default:  prdata = '0;
    endcase
  end

  // Handshake: the pass runs when the result register is free or draining.
  assign advance         = in_valid_q & (~out_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_valid_q | advance;
  assign in_take         = s_axis_tvalid_i & s_axis_tready_o;

  // Tank percent = sample * 100 / 4095. The quotient estimate
  // (x + x/4096) / 4096 is never high and at most one low.
  assign sample = s_axis_tdata_i[14:3];
  assign scaled = {1'b0, sample, 6'd0} + {2'b0, sample, 5'd0} + {5'b0, sample, 2'd0};
  assign approx = scaled + {12'd0, scaled[18:12]};
  assign quot0  = approx[18:12];
  assign rem0   = scaled - {quot0, 12'd0} + {12'd0, quot0};
  assign pct_in = quot0 + {6'd0, (rem0 >= {6'd0, FullScale})};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      dry_q    <= s_axis_tdata_i[0];
      pres_q   <= s_axis_tdata_i[1];
      day_lt_q <= s_axis_tdata_i[2];
      pct_q    <= pct_in;
    end
  end

  // One control pass: mode handler, then the shared monitor step, then the
  // alert handlers' follow-up tests on the fresh percent.
  always_comb begin
    mode_n   = mode_q;
    cd_n     = cd_q;
    ps_n     = ps_q;
    cs_n     = cs_q;
    lp_n     = lp_q;
    run_n    = run_q;
    passes_n = passes_q;
    pump_n   = pump_q;
    alert_n  = alert_q;
    fired    = 1'b0;
    mon      = 1'b0;

    unique case (mode_q) inside
      ModeMonitor: begin
        mon = 1'b1;
      end
      ModeWater: begin
        if (pres_q) begin
          mode_n = ModePaused;
          ps_n   = cd_q;
          pump_n = 1'b0;
        end else if (lp_q <= crit_q) begin
          mode_n = ModeCritical;
          cs_n   = cd_q;
          pump_n = 1'b0;
        end else begin
          // One-shot watering timer: first read arms it.
          if (!run_q) begin
            run_n    = 1'b1;
            passes_n = '0;
          end else begin
            passes_n = (passes_q < PassCountMax) ? passes_q + 1'b1 : passes_q;
            if (passes_n >= pps_q) begin
              run_n    = 1'b0;
              passes_n = '0;
              fired    = 1'b1;
            end
          end
          if (fired) begin
            if (cd_q != '0) begin
              cd_n = cd_q - 1'b1;
            end else begin
              pump_n = 1'b0;
              mode_n = ModeMonitor;
            end
          end
          mon = 1'b1;
        end
      end
      ModePaused: begin
        if (!pres_q) begin
          mode_n = ModeWater;
          cd_n   = ps_q;
          pump_n = 1'b1;
        end
        mon = 1'b1;
      end
      ModeLow, ModeCritical: begin
        alert_n = 1'b1;
        mon     = 1'b1;
      end
      default: begin
        run_n    = 1'b0;
        passes_n = '0;
        pump_n   = 1'b0;
        alert_n  = 1'b0;
        mode_n   = ModeMonitor;
      end
    endcase

    // Monitor step: take the new sample and look for a mode change.
    if (mon) begin
      lp_n = pct_q;
      if (mode_n != ModeWater) begin
        if (dry_q) begin
          mode_n = ModeWater;
          cd_n   = day_lt_q ? day_q : night_q;
          ps_n   = '0;
          cs_n   = '0;
          pump_n = 1'b1;
        end else if (pct_q <= low_q && pct_q > crit_q) begin
          mode_n = ModeLow;
        end else if (pct_q <= crit_q) begin
          mode_n = ModeCritical;
        end
      end
    end

    // Alert exits, tested after the monitor step. The critical exit resumes
    // from the saved time as the monitor step left it.
    if (mode_q == ModeLow) begin
      if (pct_q > low_q) begin
        mode_n = ModeWater;
      end else if (pct_q <= crit_q) begin
        cs_n   = cd_n;
        mode_n = ModeCritical;
      end
    end else if (mode_q == ModeCritical) begin
      if (pct_q > crit_q) begin
        alert_n = 1'b0;
        mode_n  = ModeWater;
        cd_n    = cs_n;
        pump_n  = 1'b1;
      end
    end
  end

  // Controller state update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeStart;
      cd_q     <= '0;
      ps_q     <= '0;
      cs_q     <= '0;
      lp_q     <= '0;
      run_q    <= 1'b0;
      passes_q <= '0;
      pump_q   <= 1'b0;
      alert_q  <= 1'b0;
    end else if (advance) begin
      mode_q   <= mode_n;
      cd_q     <= cd_n;
      ps_q     <= ps_n;
      cs_q     <= cs_n;
      lp_q     <= lp_n;
      run_q    <= run_n;
      passes_q <= passes_n;
      pump_q   <= pump_n;
      alert_q  <= alert_n;
    end
  end

  // Result register.
  assign press_n = {{(PressW-PctW){1'b0}}, lp_n} * PaPerPct;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {5'd0, press_n, lp_n, cd_n, alert_n, pump_n, mode_n};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Checks on internal consistency.
  a_timer_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q |-> passes_q == '0)
    else $error("timer count not cleared while idle");

  a_paused_pump_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == ModePaused |-> !pump_q)
    else $error("pump on while paused");

  a_percent_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |-> pct_q <= 7'd100)
    else $error("tank percent above 100");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("input stalled without a full pipeline");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Irrigation mode controller testbench
// Drives control passes into the stream input and checks every result item
// against a cycle-free prediction of the six-mode controller. A short
// directed table opens the run, then biased random passes follow under
// several register settings, with random idling on both stream sides.
// ---------------------------------------------------------------------------
module testbench;
  import imc_pkg::*;

  localparam int unsigned PhaseItems    = 200;
  localparam int unsigned NumFixed      = 6;
  localparam int unsigned NumRandomSets = 3;
  localparam int unsigned HoldAfter     = 500;
  localparam int unsigned HoldCycles    = 60;
  localparam int unsigned SettleCycles  = 6;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned ReportLimit   = 40;

  // One control pass and the status it leaves behind.
  typedef struct packed {
    logic            dry;
    logic            presence;
    logic            daylight;
    logic [SampleW-1:0] sample;
  } pass_t;

  typedef struct packed {
    mode_e              mode;
    logic               pump;
    logic               alert;
    logic [SecW-1:0]    seconds;
    logic [PctW-1:0]    percent;
    logic [PressW-1:0]  pressure;
  } status_t;

  typedef struct packed {
    pass_t   pass;
    logic    typed;
    status_t want;
  } directed_row_t;

  typedef struct packed {
    logic [PpsW-1:0] pps;
    logic [SecW-1:0] day;
    logic [SecW-1:0] night;
    logic [PctW-1:0] low;
    logic [PctW-1:0] crit;
  } setting_t;

  localparam status_t Computed = '{ModeStart, 1'b0, 1'b0, 16'd0, 7'd0, 15'd0};

  // Directed passes under the reset settings. Rows with a typed status open
  // the table; the rest walk pause, low alert, critical alert and their exits.
  directed_row_t directed_rows [21] = '{
    '{'{1'b1, 1'b1, 1'b1, 12'hFFF}, 1'b1,
      '{ModeMonitor, 1'b0, 1'b0, 16'd0, 7'd0, 15'd0}},
    '{'{1'b0, 1'b0, 1'b0, 12'hFFF}, 1'b1,
      '{ModeMonitor, 1'b0, 1'b0, 16'd0, 7'd100, 15'd29400}},
    '{'{1'b1, 1'b0, 1'b1, 12'h000}, 1'b1,
      '{ModeWater, 1'b1, 1'b0, 16'd30, 7'd0, 15'd0}},
    '{'{1'b0, 1'b0, 1'b0, 12'hFFF}, 1'b1,
      '{ModeCritical, 1'b0, 1'b0, 16'd30, 7'd0, 15'd0}},
    '{'{1'b0, 1'b0, 1'b0, 12'hFFF}, 1'b1,
      '{ModeWater, 1'b1, 1'b0, 16'd30, 7'd100, 15'd29400}},
    '{'{1'b0, 1'b1, 1'b0, 12'h000}, 1'b1,
      '{ModePaused, 1'b0, 1'b0, 16'd30, 7'd100, 15'd29400}},
    '{'{1'b0, 1'b1, 1'b0, 12'd615}, 1'b0, Computed},
    '{'{1'b0, 1'b0, 1'b0, 12'h000}, 1'b0, Computed},
    '{'{1'b0, 1'b0, 1'b1, 12'd100}, 1'b0, Computed},
    '{'{1'b1, 1'b0, 1'b0, 12'hFFF}, 1'b0, Computed},
    '{'{1'b0, 1'b0, 1'b0, 12'h555}, 1'b0, Computed},
    '{'{1'b0, 1'b0, 1'b1, 12'hAAA}, 1'b0, Computed},
    '{'{1'b0, 1'b1, 1'b0, 12'hFFF}, 1'b0, Computed},
    '{'{1'b1, 1'b0, 1'b1, 12'h000}, 1'b0, Computed},
    '{'{1'b0, 1'b0, 1'b0, 12'd615}, 1'b0, Computed},
    '{'{1'b0, 1'b0, 1'b0, 12'hFFF}, 1'b0, Computed},
    '{'{1'b0, 1'b1, 1'b1, 12'hFFF}, 1'b0, Computed},
    '{'{1'b0, 1'b1, 1'b0, 12'd615}, 1'b0, Computed},
    '{'{1'b0, 1'b0, 1'b0, 12'hFFF}, 1'b0, Computed},
    '{'{1'b0, 1'b0, 1'b1, 12'hFFF}, 1'b0, Computed},
    '{'{1'b0, 1'b0, 1'b0, 12'hFFF}, 1'b0, Computed}
  };

  // Register settings after the reset one: extremes, equal and inverted
  // thresholds, and a zero passes-per-second count.
  setting_t fixed_settings [NumFixed] = '{
    '{10'd1,    16'd2,     16'd1,     7'd20,  7'd10},
    '{10'd0,    16'd0,     16'd3,     7'd100, 7'd0},
    '{10'd1000, 16'hFFFF,  16'hFFFF,  7'd0,   7'd100},
    '{10'd3,    16'd1,     16'd0,     7'd50,  7'd50},
    '{10'd1023, 16'd5,     16'd5,     7'd127, 7'd127},
    '{10'd2,    16'd3,     16'd2,     7'd30,  7'd5}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [DataW-1:0]    pwdata;
  logic [DataW-1:0]    prdata;
  logic                pready;

  irrigation_mode_controller dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Predicted controller state and the settings it runs under.
  mode_e             ctl_mode;
  logic [SecW-1:0]   ctl_countdown;
  logic [SecW-1:0]   ctl_pause_saved;
  logic [SecW-1:0]   ctl_crit_saved;
  logic [PctW-1:0]   ctl_percent;
  logic              ctl_timer_on;
  logic [PpsW-1:0]   ctl_timer_count;
  logic              ctl_pump;
  logic              ctl_alert;
  logic [PpsW-1:0]   cfg_pps;
  logic [SecW-1:0]   cfg_day;
  logic [SecW-1:0]   cfg_night;
  logic [PctW-1:0]   cfg_low;
  logic [PctW-1:0]   cfg_crit;

  status_t           pending_status [$];
  int unsigned       mismatches;
  int unsigned       results_seen;
  int unsigned       items_sent;
  int unsigned       idle_cycles;
  int unsigned       runs_finished;
  int unsigned       mode_entries [6];
  int unsigned       send_streak;
  bit                hold_applied;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatches < ReportLimit) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
    mismatches++;
  endtask

  // Tank reading and the monitoring decision that follows several handlers.
  function automatic void sense_soil_and_tank(input pass_t it);
    ctl_percent = PctW'((32'(it.sample) * 100) / 4095);
    if (ctl_mode != ModeWater) begin
      if (it.dry) begin
        ctl_mode        = ModeWater;
        ctl_countdown   = it.daylight ? cfg_day : cfg_night;
        ctl_pause_saved = '0;
        ctl_crit_saved  = '0;
        ctl_pump        = 1'b1;
      end else if (ctl_percent <= cfg_low && ctl_percent > cfg_crit) begin
        ctl_mode = ModeLow;
      end else if (ctl_percent <= cfg_crit) begin
        ctl_mode = ModeCritical;
      end
    end
  endfunction

  // One-shot watering timer; true when a second has gone by.
  function automatic logic second_elapsed();
    if (!ctl_timer_on) begin
      ctl_timer_on    = 1'b1;
      ctl_timer_count = '0;
      return 1'b0;
    end
    if (ctl_timer_count < PassCountMax) ctl_timer_count++;
    if (ctl_timer_count >= cfg_pps) begin
      ctl_timer_on    = 1'b0;
      ctl_timer_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Runs one control pass on the predicted state and returns its status.
  task automatic advance_controller(input pass_t it, output status_t st);
    mode_e prior;
    prior = ctl_mode;
    case (ctl_mode)
      ModeMonitor: begin
        sense_soil_and_tank(it);
      end
      ModeWater: begin
        if (it.presence) begin
          ctl_mode        = ModePaused;
          ctl_pause_saved = ctl_countdown;
          ctl_pump        = 1'b0;
        end else if (ctl_percent <= cfg_crit) begin
          ctl_mode       = ModeCritical;
          ctl_crit_saved = ctl_countdown;
          ctl_pump       = 1'b0;
        end else begin
          if (second_elapsed()) begin
            if (ctl_countdown != '0) begin
              ctl_countdown--;
            end else begin
              ctl_pump = 1'b0;
              ctl_mode = ModeMonitor;
              runs_finished++;
            end
          end
          sense_soil_and_tank(it);
        end
      end
      ModePaused: begin
        if (!it.presence) begin
          ctl_mode      = ModeWater;
          ctl_countdown = ctl_pause_saved;
          ctl_pump      = 1'b1;
        end
        sense_soil_and_tank(it);
      end
      ModeLow: begin
        ctl_alert = 1'b1;
        sense_soil_and_tank(it);
        if (ctl_percent > cfg_low) begin
          ctl_mode = ModeWater;
        end else if (ctl_percent <= cfg_crit) begin
          ctl_crit_saved = ctl_countdown;
          ctl_mode       = ModeCritical;
        end
      end
      ModeCritical: begin
        ctl_alert = 1'b1;
        sense_soil_and_tank(it);
        if (ctl_percent > cfg_crit) begin
          ctl_alert     = 1'b0;
          ctl_mode      = ModeWater;
          ctl_countdown = ctl_crit_saved;
          ctl_pump      = 1'b1;
        end
      end
      default: begin
        ctl_timer_on    = 1'b0;
        ctl_timer_count = '0;
        ctl_pump        = 1'b0;
        ctl_alert       = 1'b0;
        ctl_mode        = ModeMonitor;
      end
    endcase
    if (ctl_mode != prior) mode_entries[ctl_mode]++;
    st = '{ctl_mode, ctl_pump, ctl_alert, ctl_countdown, ctl_percent,
           PressW'(ctl_percent * PaPerPct)};
  endtask

  // Offers one pass after a random gap and records its expected status once
  // the block takes it.
  task automatic send_pass(input pass_t it, input logic typed, input status_t want);
    int unsigned gap;
    logic        taken;
    status_t     st;
    if (send_streak > 0) begin
      send_streak--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 39) == 0) send_streak = 30;
    end
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, it.sample, it.daylight, it.presence, it.dry};
    do begin
      @(negedge clk_i);
      taken = s_axis_tready_o;
      if (taken) begin
        advance_controller(it, st);
        pending_status.push_back(typed ? want : st);
      end
      @(posedge clk_i);
    end while (!taken);
    items_sent++;
  endtask

  // Random passes: mostly a healthy tank so watering runs get far, with dry
  // soil, presence and low readings mixed in.
  task automatic send_random_passes(input int unsigned count);
    pass_t       it;
    int unsigned healthy_min;
    repeat (count) begin
      healthy_min = ((int'(cfg_low) + 1) * 4095 + 99) / 100;
      if (healthy_min > 4095) healthy_min = 4095;
      it.dry      = ($urandom_range(0, 3) == 0);
      it.presence = ($urandom_range(0, 7) == 0);
      it.daylight = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) < 7) it.sample = SampleW'($urandom_range(healthy_min, 4095));
      else it.sample = SampleW'($urandom_range(0, 4095));
      send_pass(it, 1'b0, Computed);
    end
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One register access: setup phase, access phase held until pready, then idle.
  task automatic register_access(input logic wr, input logic [2:0] idx,
                                 input logic [DataW-1:0] wdata,
                                 output logic [DataW-1:0] rdata);
    logic ready;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      ready = pready;
      rdata = prdata;
      @(posedge clk_i);
    end while (!ready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_register(input logic [2:0] idx, input logic [DataW-1:0] want);
    logic [DataW-1:0] rd;
    register_access(1'b0, idx, '0, rd);
    if (rd !== want) report_mismatch($sformatf("register %0d readback", idx), rd, want);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [DataW-1:0] value);
    logic [DataW-1:0] rd;
    register_access(1'b1, idx, value, rd);
    check_register(idx, value);
    case (idx)
      RegPps:   cfg_pps   = value[PpsW-1:0];
      RegDay:   cfg_day   = value[SecW-1:0];
      RegNight: cfg_night = value[SecW-1:0];
      RegLow:   cfg_low   = value[PctW-1:0];
      RegCrit:  cfg_crit  = value[PctW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input setting_t s);
    write_register(RegPps, DataW'(s.pps));
    write_register(RegDay, DataW'(s.day));
    write_register(RegNight, DataW'(s.night));
    write_register(RegLow, DataW'(s.low));
    write_register(RegCrit, DataW'(s.crit));
  endtask

  // Result sink: random stalls, no-stall stretches, and one long hold-off
  // that fills the block while the sender keeps offering passes.
  initial begin : result_sink
    int unsigned pause;
    int unsigned streak;
    logic        seen;
    m_axis_tready_i <= 1'b0;
    streak = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!hold_applied && results_seen >= HoldAfter) begin
        hold_applied = 1'b1;
        pause = HoldCycles;
      end else if (streak > 0) begin
        streak--;
        pause = 0;
      end else begin
        pause = $urandom_range(0, 3);
        if ($urandom_range(0, 39) == 0) streak = 30;
      end
      if (pause > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        seen = m_axis_tvalid_o;
        @(posedge clk_i);
      end while (!seen);
    end
  end

  // Result checking, sampled on the falling edge before the edge that moves the item.
  always @(negedge clk_i) begin : result_check
    status_t          want;
    logic [OutDataW-1:0] word;
    logic             moved;
    if (rst_ni) begin
      moved = s_axis_tvalid_i && s_axis_tready_o;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        moved = 1'b1;
        word  = m_axis_tdata_o;
        results_seen++;
        if (pending_status.size() == 0) begin
          report_mismatch("result item with nothing pending", word, 0);
        end else begin
          want = pending_status.pop_front();
          if (word[2:0] !== want.mode) report_mismatch("mode", word[2:0], want.mode);
          if (word[3] !== want.pump) report_mismatch("pump_on", word[3], want.pump);
          if (word[4] !== want.alert) report_mismatch("alert_on", word[4], want.alert);
          if (word[20:5] !== want.seconds)
            report_mismatch("seconds_left", word[20:5], want.seconds);
          if (word[27:21] !== want.percent)
            report_mismatch("tank_percent", word[27:21], want.percent);
          if (word[42:28] !== want.pressure)
            report_mismatch("pressure_pa", word[42:28], want.pressure);
          if (word[47:43] !== '0) report_mismatch("padding bits", word[47:43], 0);
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog on cycles with no item moving on either side.
  initial begin
    wait (idle_cycles >= WatchdogLimit);
    $display("timeout after %0d cycles without an item moving", WatchdogLimit);
    $display("irrigation_mode_controller verification failed");
    $finish;
  end

  // Main sequence.
  initial begin
    setting_t s;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    rst_ni          <= 1'b0;
    ctl_mode        = ModeStart;
    ctl_countdown   = '0;
    ctl_pause_saved = '0;
    ctl_crit_saved  = '0;
    ctl_percent     = '0;
    ctl_timer_on    = 1'b0;
    ctl_timer_count = '0;
    ctl_pump        = 1'b0;
    ctl_alert       = 1'b0;
    cfg_pps         = PpsReset;
    cfg_day         = DayReset;
    cfg_night       = NightReset;
    cfg_low         = LowReset;
    cfg_crit        = CritReset;
    mismatches      = 0;
    results_seen    = 0;
    items_sent      = 0;
    idle_cycles     = 0;
    runs_finished   = 0;
    send_streak     = 0;
    hold_applied    = 1'b0;
    foreach (mode_entries[m]) mode_entries[m] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values of the registers.
    check_register(RegPps, DataW'(PpsReset));
    check_register(RegDay, DataW'(DayReset));
    check_register(RegNight, DataW'(NightReset));
    check_register(RegLow, DataW'(LowReset));
    check_register(RegCrit, DataW'(CritReset));

    // Directed table, then random passes under the reset setting.
    foreach (directed_rows[r]) begin
      send_pass(directed_rows[r].pass, directed_rows[r].typed, directed_rows[r].want);
    end
    send_random_passes(PhaseItems - $size(directed_rows));
    wait_for_results();

    // Fixed settings, then a few random ones with short watering runs.
    for (int p = 0; p < NumFixed + NumRandomSets; p++) begin
      if (p < NumFixed) begin
        s = fixed_settings[p];
      end else begin
        s.pps   = PpsW'($urandom_range(0, 3));
        s.day   = SecW'($urandom_range(0, 4));
        s.night = SecW'($urandom_range(0, 4));
        s.low   = PctW'($urandom_range(0, 127));
        s.crit  = PctW'($urandom_range(0, 127));
      end
      apply_setting(s);
      send_random_passes(PhaseItems);
      wait_for_results();
    end

    repeat (10) @(posedge clk_i);
    $display("Sent %0d passes under %0d register settings, checked %0d results.",
             items_sent, NumFixed + NumRandomSets + 1, results_seen);
    $display("Entries: water %0d, paused %0d, low %0d, critical %0d; runs finished %0d.",
             mode_entries[ModeWater], mode_entries[ModePaused], mode_entries[ModeLow],
             mode_entries[ModeCritical], runs_finished);
    if (mismatches == 0) begin
      $display("irrigation_mode_controller verification clean");
    end else begin
      $display("irrigation_mode_controller verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/imc_pkg.sv
rtl/irrigation_mode_controller.sv
bench/testbench.sv
